// ===== hw/rtl/sgf_pkg.sv =====
// ----------------------------------------------------------------------------
// sgf_pkg
// Shared types and constants of the sample gap filler.
// ----------------------------------------------------------------------------
package sgf_pkg;

  localparam int TIME_W = 32;
  localparam int VAL_W  = 24;
  localparam int FILL_W = 6;     // holds MAX_FILL up to 63
  localparam int DATA_W = 80;    // time, cpu, mem packed
  localparam int USER_W = 3;     // kind, clipped

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ORIGINAL = 2'd0;
  localparam kind_t KIND_MIDPOINT = 2'd1;
  localparam kind_t KIND_ZERO     = 2'd2;

  // One classified sample on its way from front to back
  typedef struct packed {
    logic [TIME_W-1:0] smp_time;
    logic [VAL_W-1:0]  smp_cpu;
    logic [VAL_W-1:0]  smp_mem;
    logic [TIME_W-1:0] base_time;  // previous sample time
    logic [VAL_W-1:0]  ins_cpu;
    logic [VAL_W-1:0]  ins_mem;
    kind_t             ins_kind;
    logic [FILL_W-1:0] ins_count;  // inserted results ahead of the sample
    logic              clipped;
  } job_t;

endpackage

// ===== hw/rtl/sgf_front.sv =====
// ----------------------------------------------------------------------------
// sgf_front
// Accepts samples, measures the gap to the previous one and builds a job.
// ----------------------------------------------------------------------------
module sgf_front #(
  parameter int unsigned MAX_FILL = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [sgf_pkg::DATA_W-1:0] in_tdata,
  input  logic                  q_full,
  output logic                  push,
  output sgf_pkg::job_t         push_job
);
  import sgf_pkg::*;

  logic              have_prev_r, have_prev_nxt;
  logic [TIME_W-1:0] prev_time_r, prev_time_nxt;
  logic [VAL_W-1:0]  prev_cpu_r, prev_cpu_nxt;
  logic [VAL_W-1:0]  prev_mem_r, prev_mem_nxt;

  logic [TIME_W-1:0] t;
  logic [VAL_W-1:0]  c;
  logic [VAL_W-1:0]  m;
  logic [TIME_W:0]   diff;
  logic [TIME_W:0]   missing;
  logic [VAL_W:0]    sum_cpu;
  logic [VAL_W:0]    sum_mem;

  assign t = in_tdata[TIME_W-1:0];
  assign c = in_tdata[TIME_W+VAL_W-1:TIME_W];
  assign m = in_tdata[TIME_W+2*VAL_W-1:TIME_W+VAL_W];

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  // 33-bit signed difference; bit 32 set means a backward gap
  assign diff    = {1'b0, t} - {1'b0, prev_time_r};
  assign missing = diff - (TIME_W+1)'(1);
  assign sum_cpu = {1'b0, prev_cpu_r} + {1'b0, c};
  assign sum_mem = {1'b0, prev_mem_r} + {1'b0, m};

  always_comb begin
    push_job           = '0;
    push_job.smp_time  = t;
    push_job.smp_cpu   = c;
    push_job.smp_mem   = m;
    push_job.base_time = prev_time_r;
    push_job.ins_kind  = KIND_ORIGINAL;
    if (have_prev_r && diff == (TIME_W+1)'(2)) begin
      push_job.ins_kind  = KIND_MIDPOINT;
      push_job.ins_count = FILL_W'(1);
      push_job.ins_cpu   = sum_cpu[VAL_W:1];
      push_job.ins_mem   = sum_mem[VAL_W:1];
    end else if (have_prev_r && !diff[TIME_W] && diff > (TIME_W+1)'(2)) begin
      push_job.ins_kind = KIND_ZERO;
      if (missing > (TIME_W+1)'(MAX_FILL)) begin
        push_job.ins_count = FILL_W'(MAX_FILL);
        push_job.clipped   = 1'b1;
      end else begin
        push_job.ins_count = missing[FILL_W-1:0];
      end
    end
  end

  always_comb begin
    have_prev_nxt = have_prev_r;
    prev_time_nxt = prev_time_r;
    prev_cpu_nxt  = prev_cpu_r;
    prev_mem_nxt  = prev_mem_r;
    if (push) begin
      have_prev_nxt = 1'b1;
      prev_time_nxt = t;
      prev_cpu_nxt  = c;
      prev_mem_nxt  = m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_time_r <= '0;
      prev_cpu_r  <= '0;
      prev_mem_r  <= '0;
    end else begin
      have_prev_r <= have_prev_nxt;
      prev_time_r <= prev_time_nxt;
      prev_cpu_r  <= prev_cpu_nxt;
      prev_mem_r  <= prev_mem_nxt;
    end
  end

endmodule

// ===== hw/rtl/sgf_queue.sv =====
// ----------------------------------------------------------------------------
// sgf_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module sgf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sgf_pkg::job_t push_job,
  output logic          full,
  output logic          head_valid,
  output sgf_pkg::job_t head_job,
  input  logic          pop
);
  import sgf_pkg::*;

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/sgf_back.sv =====
// ----------------------------------------------------------------------------
// sgf_back
// Plays out one job: inserted results one per cycle while out_tready is high, then the sample itself.
// ----------------------------------------------------------------------------
module sgf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  sgf_pkg::job_t head_job,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [sgf_pkg::DATA_W-1:0] out_tdata,
  output logic [sgf_pkg::USER_W-1:0] out_tuser,
  output logic          out_tlast
);
  import sgf_pkg::*;

  logic                      valid_r, valid_nxt;
  logic [FILL_W-1:0]         cnt_r, cnt_nxt;
  logic [DATA_W-1:0]         data_r, data_nxt;
  logic [USER_W-1:0]         user_r, user_nxt;
  logic                      last_r, last_nxt;
  logic                      load;
  logic                      at_sample;
  logic [TIME_W-1:0]         ins_time;

  assign load      = head_valid && (!valid_r || out_tready);
  assign at_sample = (cnt_r == head_job.ins_count);
  assign pop       = load && at_sample;
  assign ins_time  = head_job.base_time + TIME_W'(cnt_r) + TIME_W'(1);

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    last_nxt  = last_r;
    if (valid_r && out_tready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      if (at_sample) begin
        data_nxt = {head_job.smp_mem, head_job.smp_cpu, head_job.smp_time};
        user_nxt = {head_job.clipped, KIND_ORIGINAL};
        last_nxt = 1'b1;
        cnt_nxt  = '0;
      end else begin
        data_nxt = {head_job.ins_mem, head_job.ins_cpu, ins_time};
        user_nxt = {1'b0, head_job.ins_kind};
        last_nxt = 1'b0;
        cnt_nxt  = cnt_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ===== hw/rtl/sample_gap_filler_top.sv =====
// ----------------------------------------------------------------------------
// sample_gap_filler_top
// Fills gaps in a stream of timestamped telemetry samples.
// ----------------------------------------------------------------------------
// Each accepted sample yields 1 + n result beats on the output, one beat per
// cycle while out_tready is high: n is 1 for a two-second gap (midpoint),
// min(gap - 1, MAX_FILL) for a larger gap (zero fill), and 0 otherwise. The
// back end's playout counter steps through the inserted beats before the
// sample. The front end classifies a sample in its accept cycle and can take
// a new one every cycle while the two-entry job queue has room. The last beat
// of each sample carries tlast and is the sample itself.
module sample_gap_filler_top #(
  parameter int unsigned MAX_FILL = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // sample_time[31:0], cpu_value[55:32], mem_value[79:56]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // out_time[31:0], out_cpu[55:32], out_mem[79:56]
  output logic [2:0]  out_tuser,  // sample_kind[1:0], gap_clipped[2]
  output logic        out_tlast   // last
);
  import sgf_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic head_valid;
  job_t head_job;
  logic pop;

  sgf_front #(.MAX_FILL(MAX_FILL)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  sgf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop)
  );

  sgf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// ===== hw/rtl/sgf_checker.sv =====
// ----------------------------------------------------------------------------
// sgf_checker
// Port-level checks of the sample gap filler output stream.
// ----------------------------------------------------------------------------
module sgf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import sgf_pkg::*;

  // Hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output beat changed");

  // The sample itself is the final beat and only it
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser[1:0] == KIND_ORIGINAL) == out_tlast))
    else $error("tlast does not match original kind");

  a_ins_unclipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != KIND_ORIGINAL |-> !out_tuser[2])
    else $error("inserted beat flagged clipped");

  a_zero_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_ZERO |-> out_tdata[79:32] == '0)
    else $error("zero fill beat carries values");

endmodule

bind sample_gap_filler_top sgf_checker u_sgf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
